FILE: hdl/b64e_pkg.sv
package b64e_pkg;

  // Default number of closed groups that can wait between front and back.
  localparam int B64E_QUEUE_DEPTH = 2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [1:0] LAST_CHAR_IDX = 2'd3;

  // One closed group of up to three bytes, most significant byte first.
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  nbytes;
    logic        last;
  } group_t;

  // Custom alphabet: digits, then lower case, then upper case, then '+' and '/'.
  function automatic logic [7:0] b64e_char(input logic [5:0] sx);
    logic [7:0] ch;
    ch = 8'h2F;
    case (sx) inside
      [6'd0:6'd9]:   ch = 8'h30 + {2'b00, sx};
      [6'd10:6'd35]: ch = 8'h61 + {2'b00, sx} - 8'd10;
      [6'd36:6'd61]: ch = 8'h41 + {2'b00, sx} - 8'd36;
      6'd62:         ch = 8'h2B;
      default:       ch = 8'h2F;
    endcase
    return ch;
  endfunction

endpackage

FILE: hdl/b64e_front.sv
module b64e_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_data_byte,
  input  logic            in_last_byte,
  input  logic            q_full,
  output logic            q_push,
  output b64e_pkg::group_t q_data
);
  import b64e_pkg::*;

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        accept;
  logic        closes;

  // Hold off new bytes while no queue slot is free.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign closes   = cnt_r[1] || in_last_byte;

  // Build the group that this byte closes; a count of three acts like two.
  always_comb begin
    q_push = accept && closes;
    q_data.last = in_last_byte;
    if (cnt_r[1]) begin
      q_data.bits   = {pend_r, in_data_byte};
      q_data.nbytes = 2'd3;
    end else if (cnt_r[0]) begin
      q_data.bits   = {pend_r[7:0], in_data_byte, 8'h00};
      q_data.nbytes = 2'd2;
    end else begin
      q_data.bits   = {in_data_byte, 16'h0000};
      q_data.nbytes = 2'd1;
    end
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      if (closes) begin
        pend_nxt = 16'h0000;
        cnt_nxt  = 2'd0;
      end else begin
        pend_nxt = {pend_r[7:0], in_data_byte};
        cnt_nxt  = cnt_r + 2'd1;
      end
    end
  end

  // Pending byte store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 16'h0000;
      cnt_r  <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: hdl/b64e_queue.sv
module b64e_queue #(
  parameter int QUEUE_DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  b64e_pkg::group_t push_data,
  output logic             full,
  input  logic             pop,
  output b64e_pkg::group_t pop_data,
  output logic             empty
);
  import b64e_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  group_t          slot_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full     = (cnt_r == FullCnt);
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Group storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hdl/b64e_back.sv
module b64e_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  b64e_pkg::group_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_code_char,
  output logic             out_group_end,
  output logic             out_message_end
);
  import b64e_pkg::*;

  group_t     grp_r, grp_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       oval_r, oval_nxt;
  logic [7:0] ochar_r, ochar_nxt;
  logic       ogend_r, ogend_nxt;
  logic       omend_r, omend_nxt;
  logic       slot_free;
  logic       emit;
  logic [5:0] sx;
  logic       is_pad;

  assign slot_free = !oval_r || !out_stall;
  assign emit      = busy_r && slot_free;

  // Pick the sextet for the current character, most significant first.
  always_comb begin
    case (idx_r)
      2'd0:    sx = grp_r.bits[23:18];
      2'd1:    sx = grp_r.bits[17:12];
      2'd2:    sx = grp_r.bits[11:6];
      default: sx = grp_r.bits[5:0];
    endcase
    is_pad = ((idx_r == 2'd2) && (grp_r.nbytes < 2'd2)) ||
             ((idx_r == LAST_CHAR_IDX) && (grp_r.nbytes < 2'd3));
  end

  // Character sequencing and output register loading.
  always_comb begin
    grp_nxt   = grp_r;
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    oval_nxt  = oval_r && out_stall;
    ochar_nxt = ochar_r;
    ogend_nxt = ogend_r;
    omend_nxt = omend_r;
    if (emit) begin
      oval_nxt  = 1'b1;
      ochar_nxt = is_pad ? PAD_CHAR : b64e_char(sx);
      ogend_nxt = (idx_r == LAST_CHAR_IDX);
      omend_nxt = (idx_r == LAST_CHAR_IDX) && grp_r.last;
      idx_nxt   = idx_r + 2'd1;
      if (idx_r == LAST_CHAR_IDX) begin
        busy_nxt = 1'b0;
      end
    end
    q_pop = !q_empty && (!busy_r || (emit && (idx_r == LAST_CHAR_IDX)));
    if (q_pop) begin
      grp_nxt  = q_data;
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
      oval_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      oval_r <= oval_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    grp_r   <= grp_nxt;
    ochar_r <= ochar_nxt;
    ogend_r <= ogend_nxt;
    omend_r <= omend_nxt;
  end

  assign out_valid       = oval_r;
  assign out_code_char   = ochar_r;
  assign out_group_end   = ogend_r;
  assign out_message_end = omend_r;

endmodule

FILE: hdl/base64_encoder_custom_alphabet_top.sv
// Streaming base64 encoder, custom alphabet (0-9, a-z, A-Z, '+', '/').
// Input channel: one byte per beat on in_data_byte, with in_last_byte set
// on the final byte of a message. A beat moves when in_valid is high and
// in_stall is low. Output channel: one character per beat on out_code_char,
// with out_group_end on the fourth character of each group and
// out_message_end on the fourth character of the message's last group.
// Every third byte, or a last byte, closes a group that yields exactly four
// characters; short final groups are padded with '='.
// A closing group is written into the queue, then into the back end's
// group register, and each character into the output register. The back
// end emits one character per cycle unless idle or stalled, so the single
// character output port sets throughput. Bytes that do not close a group
// are taken every cycle while a queue slot is free.
// A queue of QUEUE_DEPTH closed groups sits between the byte side and the
// character side; in_stall rises only when that queue is full.
// When the receiver stalls, the output beat holds and the queue fills.
// Synchronous reset clears pending bytes, the queue and the output valid.
module base64_encoder_custom_alphabet_top #(
  parameter int QUEUE_DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_code_char,
  output logic       out_group_end,
  output logic       out_message_end
);
  import b64e_pkg::*;

  group_t push_data;
  group_t pop_data;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  // Byte collection and group closing.
  b64e_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (full),
    .q_push       (push),
    .q_data       (push_data)
  );

  // Closed groups waiting for the character side.
  b64e_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // Character emission.
  b64e_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (empty),
    .q_data          (pop_data),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_char   (out_code_char),
    .out_group_end   (out_group_end),
    .out_message_end (out_message_end)
  );

endmodule

FILE: bench/b64e_checker.sv
`timescale 1ns / 100ps

module b64e_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_code_char,
  input  logic       out_group_end,
  input  logic       out_message_end,
  output int         error_count,
  output int         chars_pending
);

  // Sextet value 0 maps to the leftmost character of this string.
  localparam logic [8*64-1:0] ALPHABET =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ+/";

  typedef struct packed {
    logic [7:0] code_char;
    logic       group_end;
    logic       message_end;
  } char_beat_t;

  char_beat_t  expected_chars[$];
  logic [15:0] held_bytes;
  logic [1:0]  held_count;

  function automatic logic [7:0] alphabet_char(input logic [5:0] idx);
    return ALPHABET[8*(63 - int'(idx)) +: 8];
  endfunction

  // Store a byte that leaves the group open, or turn the closed group into
  // its four characters, padding short final groups.
  task automatic encode_byte(input logic [7:0] data, input logic last);
    logic [23:0] grp;
    int          nbytes;
    char_beat_t  beat;
    if (held_count < 2'd2 && !last) begin
      held_bytes = {held_bytes[7:0], data};
      held_count = held_count + 2'd1;
    end else begin
      if (held_count >= 2'd2) begin
        grp    = {held_bytes, data};
        nbytes = 3;
      end else if (held_count == 2'd1) begin
        grp    = {held_bytes[7:0], data, 8'h00};
        nbytes = 2;
      end else begin
        grp    = {data, 16'h0000};
        nbytes = 1;
      end
      for (int k = 0; k < 4; k++) begin
        if (k >= nbytes + 1) begin
          beat.code_char = b64e_pkg::PAD_CHAR;
        end else begin
          beat.code_char = alphabet_char(grp[18 - 6*k +: 6]);
        end
        beat.group_end   = (k == 3);
        beat.message_end = (k == 3) && last;
        expected_chars.push_back(beat);
      end
      held_bytes = 16'h0000;
      held_count = 2'd0;
    end
  endtask

  // Predict on every input beat and compare every output beat in order.
  always @(posedge clk) begin
    char_beat_t want;
    if (!rst_n) begin
      expected_chars.delete();
      held_bytes  = 16'h0000;
      held_count  = 2'd0;
      error_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_byte(in_data_byte, in_last_byte);
      end
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character beat: code_char %h", out_code_char);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_code_char !== want.code_char) begin
            $error("code_char: expected %h, got %h", want.code_char, out_code_char);
            error_count++;
          end
          if (out_group_end !== want.group_end) begin
            $error("group_end: expected %b, got %b", want.group_end, out_group_end);
            error_count++;
          end
          if (out_message_end !== want.message_end) begin
            $error("message_end: expected %b, got %b", want.message_end,
                   out_message_end);
            error_count++;
          end
        end
      end
    end
    chars_pending = expected_chars.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RX_HOLD_CYCLES = 150;
  localparam int ITEM_TARGET    = 220;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_code_char;
  logic       out_group_end;
  logic       out_message_end;
  int         error_count;
  int         chars_pending;

  // Pacing controls for the sender and the receiver, set by the stimulus.
  bit tx_fast;
  bit rx_fast;
  bit rx_hold_request;

  base64_encoder_custom_alphabet_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_char   (out_code_char),
    .out_group_end   (out_group_end),
    .out_message_end (out_message_end)
  );

  b64e_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_char   (out_code_char),
    .out_group_end   (out_group_end),
    .out_message_end (out_message_end),
    .error_count     (error_count),
    .chars_pending   (chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one byte after a random gap, none when tx_fast is set, and hold it until the beat is taken.
  task automatic send_byte(input logic [7:0] data, input logic last);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Receiver: random stall before each character unless rx_fast is set, with one long hold-off.
  initial begin : receiver
    int wait_cycles;
    bit hold_done;
    out_stall = 1'b1;
    hold_done = 1'b0;
    forever begin
      wait_cycles = rx_fast ? 0 : $urandom_range(0, 7);
      if (rx_hold_request && !hold_done) begin
        wait_cycles = RX_HOLD_CYCLES;
        hold_done   = 1'b1;
      end
      repeat (wait_cycles) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Stop the run when no beat moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int  sent;
    int  msg_len;
    bit  did_hold;
    bit  did_drain;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data_byte    = 8'h00;
    in_last_byte    = 1'b0;
    tx_fast         = 1'b0;
    rx_fast         = 1'b0;
    rx_hold_request = 1'b0;
    did_hold        = 1'b0;
    did_drain       = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Single-byte messages at both data extremes, padded with two pads.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // Two-byte message, padded with one pad.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    // Full group closed by the last mark.
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Full group without a last mark, then a short final group of two.
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    // Full group followed by a one-byte final group.
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'hFB, 1'b1);
    // Group made of the two symbol characters only.
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b1);
    sent = 19;

    // Random messages, mostly short, with a few long ones.
    while (sent < ITEM_TARGET) begin
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 3) == 0);
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                            : $urandom_range(1, 8);
      if (!did_hold && sent >= 80) begin
        // Receiver holds off while the sender keeps offering bytes.
        did_hold        = 1'b1;
        rx_hold_request = 1'b1;
        tx_fast         = 1'b1;
        msg_len         = 18;
      end else if (!did_drain && sent >= 150) begin
        // Sender pauses until every expected character has arrived.
        did_drain = 1'b1;
        go_idle();
        while (chars_pending != 0) @(negedge clk);
      end
      for (int i = 0; i < msg_len; i++) begin
        send_byte(8'($urandom_range(0, 255)), i == msg_len - 1);
      end
      sent += msg_len;
    end

    go_idle();
    rx_fast = 1'b0;
    while (chars_pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
